// ----- hw/rtl/bsoc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsoc_pkg
// Shared constants, lookup tables and types of the battery charge estimator.
// ----------------------------------------------------------------------------
package bsoc_pkg;

   // Sample and register widths
   localparam int ADC_BITS   = 12;
   localparam int GAIN_W     = 14;
   localparam int REF_W      = 13;
   localparam int CSR_DATA_W = 14;
   localparam int CSR_IDX_W  = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADC_REF      = 2'd1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd6373;
   localparam logic [REF_W-1:0]  REF_RESET  = 13'd3300;

   // Datapath widths
   localparam int PROD1_W   = ADC_BITS + REF_W;     // code * ref
   localparam int PROD2_W   = PROD1_W + 4;          // times ten
   localparam int PROD3_W   = PROD2_W + GAIN_W;     // times gain
   localparam int SCALED_W  = PROD3_W - 12;         // after dropping Q12 fraction
   localparam int VOLT_W    = 20;                   // full voltage quotient
   localparam int VOLT_OUT_W = 18;
   localparam int CAP_W     = 7;

   // Division by the ADC full scale, 2^ADC_BITS - 1, by folding
   localparam int FOLD_SUM_W = ADC_BITS + 1;
   localparam logic [FOLD_SUM_W-1:0] ADC_FULL_SCALE = FOLD_SUM_W'((1 << ADC_BITS) - 1);

   // Serial divider geometry
   localparam int DIV_REM_W   = 15;
   localparam int DIV_SHIFT_W = 20;
   localparam int DIV_CNT_W   = 5;
   localparam int INTERP_QBITS = 4;

   localparam logic [VOLT_OUT_W-1:0] VOLT_SAT = 18'h3FFFF;

   // Charge curve, descending voltage in 0.1 mV
   localparam int TABLE_ENTRIES = 13;
   localparam int SEG_BITS      = $clog2(TABLE_ENTRIES);

   localparam logic [15:0] THR_VOLT [TABLE_ENTRIES] = '{
      16'd41700, 16'd40400, 16'd39400, 16'd38400, 16'd37400, 16'd36500, 16'd36100,
      16'd35800, 16'd35500, 16'd35200, 16'd35000, 16'd34500, 16'd33000
   };
   localparam logic [CAP_W-1:0] THR_CAP [TABLE_ENTRIES] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
      7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
   };
   localparam logic [CAP_W-1:0] CAP_FULL = 7'd100;

   // Divider command and status
   typedef struct packed {
      logic                   start;
      logic [DIV_REM_W-1:0]   rem_init;
      logic [DIV_SHIFT_W-1:0] low_bits;
      logic [DIV_CNT_W-1:0]   count;
      logic [DIV_REM_W-1:0]   divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [DIV_SHIFT_W-1:0] quotient;
   } div_stat_type;

endpackage

// ----- hw/rtl/bsoc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsoc_front
// Accepts ADC requests and scales each one through a three-stage multiply
// pipeline: code * reference, times ten, times divider gain (Q12 dropped).
// ----------------------------------------------------------------------------
module bsoc_front import bsoc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ADC_BITS-1:0] req_adc_code,
   input  logic [GAIN_W-1:0]   gain,
   input  logic [REF_W-1:0]    ref_mv,
   input  logic                queue_full,
   output logic                push_valid,
   output logic [SCALED_W-1:0] push_data
);

   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                s3_valid_ff, s3_valid_in;
   logic [PROD1_W-1:0]  p1_ff, p1_in;
   logic [PROD2_W-1:0]  p2_ff, p2_in;
   logic [SCALED_W-1:0] p3_ff, p3_in;
   logic [PROD3_W-1:0]  p3_full;
   logic                advance;

   // Move the whole pipe unless the last stage is blocked by a full queue
   assign advance   = !s3_valid_ff || !queue_full;
   assign req_stall = !advance;

   // Stage arithmetic
   always_comb begin
      p1_in   = PROD1_W'(req_adc_code) * PROD1_W'(ref_mv);
      p2_in   = (PROD2_W'(p1_ff) << 3) + (PROD2_W'(p1_ff) << 1);
      p3_full = PROD3_W'(p2_ff) * PROD3_W'(gain);
      p3_in   = p3_full[PROD3_W-1:12];
   end

   assign s1_valid_in = advance ? req_valid   : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = advance ? s2_valid_ff : s3_valid_ff;

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
      end
   end

   assign push_valid = s3_valid_ff;
   assign push_data  = p3_ff;

endmodule

// ----- hw/rtl/bsoc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsoc_queue
// Two-entry queue of scaled samples between the front and the back end.
// ----------------------------------------------------------------------------
module bsoc_queue import bsoc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [SCALED_W-1:0] push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output logic [SCALED_W-1:0] head_data
);

   logic [SCALED_W-1:0] entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the new entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/bsoc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsoc_div
// Restoring serial divider, one quotient bit per cycle. The caller preloads
// the upper dividend bits as the partial remainder (they must be below the
// divisor) and the remaining bits left-aligned, with the step count.
// ----------------------------------------------------------------------------
module bsoc_div import bsoc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output div_stat_type stat
);

   logic [DIV_REM_W-1:0]   rem_ff, rem_in;
   logic [DIV_SHIFT_W-1:0] shift_ff, shift_in;
   logic [DIV_SHIFT_W-1:0] quot_ff, quot_in;
   logic [DIV_REM_W-1:0]   divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [DIV_REM_W:0]     trial;
   logic [DIV_REM_W:0]     diff;
   logic                   fits;

   // One subtract-and-compare step
   always_comb begin
      trial = {rem_ff, shift_ff[DIV_SHIFT_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});
   end

   always_comb begin
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      done_in    = 1'b0;
      if (cmd.start) begin
         rem_in     = cmd.rem_init;
         shift_in   = cmd.low_bits;
         quot_in    = '0;
         divisor_in = cmd.divisor;
         cnt_in     = cmd.count;
      end else if (cnt_ff != '0) begin
         rem_in   = fits ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
         shift_in = {shift_ff[DIV_SHIFT_W-2:0], 1'b0};
         quot_in  = {quot_ff[DIV_SHIFT_W-2:0], fits};
         cnt_in   = cnt_ff - DIV_CNT_W'(1);
         done_in  = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   // Step counter and completion flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy     = (cnt_ff != '0);
   assign stat.done     = done_ff;
   assign stat.quotient = quot_ff;

endmodule

// ----- hw/rtl/bsoc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsoc_back
// Pops scaled samples, folds them down to a voltage (division by the ADC
// full scale by folding and one correction), classifies the voltage against the charge curve,
// interpolates inside a segment and drives the response register.
// ----------------------------------------------------------------------------
module bsoc_back import bsoc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  logic [SCALED_W-1:0]   queue_head,
   output logic                  queue_pop,
   output div_cmd_type           div_cmd,
   input  div_stat_type          div_stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CAP_W-1:0]      rsp_capacity_percent,
   output logic [VOLT_OUT_W-1:0] rsp_voltage_tenth_mv
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_VDIV = 6'b000010,
      ST_LOOK = 6'b000100,
      ST_PREP = 6'b001000,
      ST_IDIV = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [VOLT_W-1:0]      volt_ff, volt_in;
   logic [VOLT_W-1:0]      fold_ff, fold_in;
   logic [SEG_BITS-1:0]    idx_ff, idx_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [CAP_W-1:0]       last_cap_ff, last_cap_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CAP_W-1:0]       rsp_cap_ff;
   logic [VOLT_OUT_W-1:0]  rsp_volt_ff;
   logic                   rsp_load;

   logic [FOLD_SUM_W-1:0]  fold_sum;
   logic                   fold_carry;
   logic                   above_top;
   logic                   in_segment;
   logic                   below_bottom;
   logic [SEG_BITS-1:0]    seg_idx;
   logic [SEG_BITS-1:0]    upper_idx;
   logic [15:0]            volt_off;
   logic [13:0]            seg_dv;
   logic [3:0]             seg_dc;
   logic [17:0]            interp_n;
   logic [18:0]            interp_num;

   // Divide by 4095: x = a*4096 + b gives x/4095 = a + (a + b)/4095; folding
   // a + b the same way leaves a remainder that needs at most one correction
   always_comb begin
      fold_sum   = FOLD_SUM_W'(fold_ff[VOLT_W-1:ADC_BITS])
                   + FOLD_SUM_W'(fold_ff[ADC_BITS-1:0]);
      fold_carry = (fold_sum >= ADC_FULL_SCALE);
   end

   // Classify the voltage: first threshold exceeded, scanning from the top
   always_comb begin
      above_top  = (volt_ff > VOLT_W'(THR_VOLT[0]));
      in_segment = 1'b0;
      seg_idx    = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 1; i--) begin
         if (volt_ff > VOLT_W'(THR_VOLT[i])) begin
            in_segment = 1'b1;
            seg_idx    = SEG_BITS'(i);
         end
      end
      below_bottom = (volt_ff < VOLT_W'(THR_VOLT[TABLE_ENTRIES-1]));
   end

   // Interpolation numerator 2*(v - V[i])*dc + dV, rounding half up
   always_comb begin
      upper_idx  = idx_ff - SEG_BITS'(1);
      volt_off   = volt_ff[15:0] - THR_VOLT[idx_ff];
      seg_dv     = 14'(THR_VOLT[upper_idx] - THR_VOLT[idx_ff]);
      seg_dc     = 4'(THR_CAP[upper_idx] - THR_CAP[idx_ff]);
      interp_n   = 18'(volt_off[13:0]) * 18'(seg_dc);
      interp_num = {interp_n, 1'b0} + 19'(seg_dv);
   end

   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      volt_in     = volt_ff;
      fold_in     = fold_ff;
      idx_in      = idx_ff;
      cap_in      = cap_ff;
      last_cap_in = last_cap_ff;
      queue_pop   = 1'b0;
      div_cmd     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               volt_in   = VOLT_W'(queue_head[SCALED_W-1:ADC_BITS]);
               fold_in   = VOLT_W'(queue_head[SCALED_W-1:ADC_BITS])
                           + VOLT_W'(queue_head[ADC_BITS-1:0]);
               state_in  = ST_VDIV;
            end
         end
         ST_VDIV: begin
            volt_in  = volt_ff + VOLT_W'(fold_ff[VOLT_W-1:ADC_BITS])
                       + VOLT_W'(fold_carry);
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            idx_in = seg_idx;
            if (above_top) begin
               cap_in   = CAP_FULL;
               state_in = ST_FIN;
            end else if (in_segment) begin
               state_in = ST_PREP;
            end else if (below_bottom) begin
               cap_in   = '0;
               state_in = ST_FIN;
            end else begin
               cap_in   = last_cap_ff;
               state_in = ST_FIN;
            end
         end
         ST_PREP: begin
            div_cmd.start    = 1'b1;
            div_cmd.rem_init = interp_num[18:INTERP_QBITS];
            div_cmd.low_bits = {interp_num[INTERP_QBITS-1:0],
                                (DIV_SHIFT_W-INTERP_QBITS)'(0)};
            div_cmd.count    = DIV_CNT_W'(INTERP_QBITS);
            div_cmd.divisor  = {seg_dv, 1'b0};
            state_in         = ST_IDIV;
         end
         ST_IDIV: begin
            if (div_stat.done) begin
               cap_in   = THR_CAP[idx_ff] + CAP_W'(div_stat.quotient[INTERP_QBITS-1:0]);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               last_cap_in = cap_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on load, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_cap_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_cap_ff  <= last_cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and response payload
   always_ff @(posedge clock) begin
      volt_ff <= volt_in;
      fold_ff <= fold_in;
      idx_ff  <= idx_in;
      cap_ff  <= cap_in;
      if (rsp_load) begin
         rsp_cap_ff  <= cap_ff;
         rsp_volt_ff <= (volt_ff[VOLT_W-1:VOLT_OUT_W] != '0) ? VOLT_SAT
                                                             : volt_ff[VOLT_OUT_W-1:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_capacity_percent = rsp_cap_ff;
   assign rsp_voltage_tenth_mv = rsp_volt_ff;

`ifndef SYNTH
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_rsp_cap_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cap_ff <= CAP_FULL))
      else $error("capacity above full scale");

   a_interp_quot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDIV && div_stat.done) |-> (div_stat.quotient <= DIV_SHIFT_W'(10)))
      else $error("interpolation step exceeds segment span");
`endif

endmodule

// ----- hw/rtl/battery_soc_interpolator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_soc_interpolator_unit
// Turns raw battery ADC samples into a voltage and a state-of-charge estimate.
// ----------------------------------------------------------------------------
// Usage:
//   Requests carry one 12-bit ADC code on req_adc_code, taken when req_valid
//   is high and req_stall is low; each yields one response with the capacity
//   in percent and the voltage in 0.1 mV (saturated at 18 bits), taken when
//   rsp_valid is high and rsp_stall is low. The csr port writes the divider
//   gain (index 0, Q12) and the ADC reference in mV (index 1); write only
//   while no request is in flight.
//   Between a taken request and rsp_valid lie three multiply stages, the
//   queue, fold-and-correct division by 4095, the lookup, a 4-step serial
//   division for the interpolation (only inside a segment) with its start
//   and result states, and the response register. The back end works on
//   one request at a time and pops the next only after loading the response.
//   Reset restores the default gain and reference, clears the remembered
//   capacity and empties the pipeline, queue and response register.
//   When the receiver stalls the response holds; the front end and the
//   two-entry queue keep accepting requests until full, then raise req_stall.
// ----------------------------------------------------------------------------
module battery_soc_interpolator_unit import bsoc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ADC_BITS-1:0]   req_adc_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CAP_W-1:0]      rsp_capacity_percent,
   output logic [VOLT_OUT_W-1:0] rsp_voltage_tenth_mv,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [REF_W-1:0]    ref_ff, ref_in;
   logic                push_valid;
   logic [SCALED_W-1:0] push_data;
   logic                queue_full;
   logic                queue_empty;
   logic                queue_pop;
   logic [SCALED_W-1:0] queue_head;
   div_cmd_type         div_cmd;
   div_stat_type        div_stat;

   // Decode configuration writes
   always_comb begin
      gain_in = gain_ff;
      ref_in  = ref_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DIVIDER_GAIN: gain_in = csr_wdata[GAIN_W-1:0];
            CSR_ADC_REF:      ref_in  = csr_wdata[REF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         ref_ff  <= REF_RESET;
      end else begin
         gain_ff <= gain_in;
         ref_ff  <= ref_in;
      end
   end

   bsoc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_adc_code (req_adc_code),
      .gain         (gain_ff),
      .ref_mv       (ref_ff),
      .queue_full   (queue_full),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   bsoc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (queue_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head_data (queue_head)
   );

   bsoc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   bsoc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .queue_empty          (queue_empty),
      .queue_head           (queue_head),
      .queue_pop            (queue_pop),
      .div_cmd              (div_cmd),
      .div_stat             (div_stat),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_capacity_percent (rsp_capacity_percent),
      .rsp_voltage_tenth_mv (rsp_voltage_tenth_mv)
   );

endmodule

// ----- test/battery_soc_interpolator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_soc_interpolator_unit_tb
// Self-checking bench for the battery voltage and charge estimator.
// A scoreboard class predicts the voltage and charge of every accepted ADC
// sample, keeps them in order and compares each response field by field.
// The run steps through several gain and reference settings, including the
// extremes and degenerate zero values. The settings rotate through four
// sender and receiver flow-control mixes, and two long response holds
// back the pipeline up into the request port.
// ----------------------------------------------------------------------------

class charge_scoreboard;

   typedef struct packed {
      bit [bsoc_pkg::CAP_W-1:0]      capacity;
      bit [bsoc_pkg::VOLT_OUT_W-1:0] voltage;
   } reading_type;

   // Charge curve in 0.1 mV, descending, with its percentages
   longint unsigned curve_volt [13];
   longint unsigned curve_cap  [13];

   bit [bsoc_pkg::GAIN_W-1:0] gain_q12;
   bit [bsoc_pkg::REF_W-1:0]  ref_mv;
   bit [bsoc_pkg::CAP_W-1:0]  prev_capacity;
   reading_type               awaited [$];
   int                        mismatches;
   int                        checked;

   function new();
      curve_volt = '{41700, 40400, 39400, 38400, 37400, 36500, 36100,
                     35800, 35500, 35200, 35000, 34500, 33000};
      curve_cap  = '{100, 90, 80, 70, 60, 50, 40, 30, 20, 15, 10, 5, 0};
      gain_q12      = 14'd6373;
      ref_mv        = 13'd3300;
      prev_capacity = '0;
      mismatches    = 0;
      checked       = 0;
   endfunction

   // Mirror a register write; the reference register keeps its low 13 bits
   function void write_reg(bit [bsoc_pkg::CSR_IDX_W-1:0] index,
                           bit [bsoc_pkg::CSR_DATA_W-1:0] data);
      if (index == bsoc_pkg::CSR_DIVIDER_GAIN) begin
         gain_q12 = data;
      end else if (index == bsoc_pkg::CSR_ADC_REF) begin
         ref_mv = data[bsoc_pkg::REF_W-1:0];
      end
   endfunction

   // Unsaturated battery voltage in 0.1 mV for one ADC code
   function longint unsigned scaled_voltage(bit [11:0] code);
      longint unsigned num;
      num = code;
      num = num * ref_mv;
      num = num * 10;
      num = num * gain_q12;
      return num / (64'd4095 * 64'd4096);
   endfunction

   // Piecewise-linear charge lookup with half-up rounding
   function bit [bsoc_pkg::CAP_W-1:0] charge_of(longint unsigned volt);
      longint unsigned span;
      longint unsigned step;
      longint unsigned frac;
      longint unsigned level;
      for (int i = 0; i < 13; i++) begin
         if (volt > curve_volt[i]) begin
            if (i == 0) begin
               level = curve_cap[0];
            end else begin
               span  = curve_volt[i-1] - curve_volt[i];
               step  = curve_cap[i-1] - curve_cap[i];
               frac  = (volt - curve_volt[i]) * step;
               level = curve_cap[i] + (2 * frac + span) / (2 * span);
            end
            return level[bsoc_pkg::CAP_W-1:0];
         end
      end
      // Below the bottom point drop to empty; exactly on it hold the last value
      if (volt < curve_volt[12]) return '0;
      return prev_capacity;
   endfunction

   function void note_sample(bit [11:0] code);
      longint unsigned volt;
      reading_type     reading;
      volt             = scaled_voltage(code);
      reading.capacity = charge_of(volt);
      reading.voltage  = (volt > 262143) ? 18'h3FFFF : volt[17:0];
      prev_capacity    = reading.capacity;
      awaited.push_back(reading);
   endfunction

   function void check_reading(logic [bsoc_pkg::CAP_W-1:0] capacity,
                               logic [bsoc_pkg::VOLT_OUT_W-1:0] voltage);
      reading_type want;
      if (awaited.size() == 0) begin
         mismatches++;
         if (mismatches <= 200)
            $display("%0t: response with none pending: capacity %0d voltage %0d",
                     $time, capacity, voltage);
         return;
      end
      want = awaited.pop_front();
      checked++;
      if (capacity !== want.capacity) begin
         mismatches++;
         if (mismatches <= 200)
            $display("%0t: capacity expected %0d actual %0d",
                     $time, want.capacity, capacity);
      end
      if (voltage !== want.voltage) begin
         mismatches++;
         if (mismatches <= 200)
            $display("%0t: voltage expected %0d actual %0d",
                     $time, want.voltage, voltage);
      end
   endfunction

endclass

module battery_soc_interpolator_unit_tb;
   import bsoc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [ADC_BITS-1:0]   req_adc_code = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [CAP_W-1:0]      rsp_capacity_percent;
   logic [VOLT_OUT_W-1:0] rsp_voltage_tenth_mv;
   logic                  csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   charge_scoreboard board = new();

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int cycle_count     = 0;
   int long_hold_asked = 0;
   int long_hold_given = 0;
   int hold_left       = 0;
   int settings_used   = 0;
   int thr_code [13];
   int band_lo;
   int band_hi;

   always #6 clock = ~clock;

   battery_soc_interpolator_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_adc_code         (req_adc_code),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_capacity_percent (rsp_capacity_percent),
      .rsp_voltage_tenth_mv (rsp_voltage_tenth_mv),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // Check accepted responses and pick the stall for the next cycle
   always @(posedge clock) begin : response_side
      logic stall_next;
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_reading(rsp_capacity_percent, rsp_voltage_tenth_mv);
      end
      if (rsp_valid && long_hold_asked > long_hold_given) begin
         hold_left = LONG_HOLD;
         long_hold_given++;
      end
      if (hold_left > 0) begin
         stall_next = 1'b1;
         hold_left--;
      end else begin
         stall_next = ($urandom_range(0, 99) < recv_stall_pct);
      end
      rsp_stall <= stall_next;
   end

   // Abort a hung run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Drive the write onto the port and wait for a clock edge; the caller drops the enable
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(index, data);
   endtask

   // Find the codes that land on each threshold and the band worth sampling
   task automatic survey_codes();
      longint unsigned volt;
      band_lo = -1;
      band_hi = -1;
      for (int i = 0; i < 13; i++) thr_code[i] = -1;
      for (int code = 0; code < 4096; code++) begin
         volt = board.scaled_voltage(ADC_BITS'(code));
         if (volt >= 32800 && band_lo < 0) band_lo = code;
         if (volt <= 41900) band_hi = code;
         for (int i = 0; i < 13; i++) begin
            if (thr_code[i] < 0 && volt >= board.curve_volt[i]) thr_code[i] = code;
         end
      end
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] gain,
                                input logic [CSR_DATA_W-1:0] ref_value);
      write_reg(CSR_DIVIDER_GAIN, gain);
      write_reg(CSR_ADC_REF, ref_value);
      write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      settings_used++;
      survey_codes();
   endtask

   function automatic logic [ADC_BITS-1:0] pick_code();
      int roll;
      int i;
      roll = $urandom_range(0, 99);
      if (band_lo >= 0 && band_lo <= band_hi && roll < 50) begin
         return ADC_BITS'($urandom_range(band_lo, band_hi));
      end
      if (roll < 70) begin
         i = $urandom_range(0, 12);
         if (thr_code[i] >= 0)
            return ADC_BITS'(thr_code[i] - $urandom_range(0, (thr_code[i] > 0) ? 1 : 0));
      end
      return ADC_BITS'($urandom_range(0, 4095));
   endfunction

   // Offer one request, idling first at random, and wait for its acceptance
   task automatic send_sample(input logic [ADC_BITS-1:0] code);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_adc_code <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(code);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.awaited.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] gain;
      logic [CSR_DATA_W-1:0] ref_value;
      int                    count;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, alternating bits, every threshold at reset values
      survey_codes();
      send_sample(12'd0);
      send_sample(12'hFFF);
      send_sample(12'hAAA);
      send_sample(12'h555);
      send_sample(12'd1);
      for (int i = 0; i < 13; i++) send_sample(ADC_BITS'(thr_code[i]));
      send_sample(ADC_BITS'(thr_code[0] - 1));

      // Unity gain at 3.3 V puts full scale exactly on the bottom point
      wait_drained();
      apply_setting(14'd4096, 14'd3300);
      send_sample(12'hFFF);
      send_sample(12'hFFE);
      send_sample(12'hFFF);

      // Random phases across register settings and flow-control mixes
      for (int phase = 0; phase < 15; phase++) begin
         case (phase)
            0, 14: begin gain = 14'd6373;  ref_value = 14'd3300; end
            1:     begin gain = 14'd16383; ref_value = 14'd5000; end
            2:     begin gain = 14'd4096;  ref_value = 14'd5000; end
            3:     begin gain = 14'd16383; ref_value = 14'd1000; end
            4:     begin gain = 14'd4096;  ref_value = 14'd1000; end
            5:     begin gain = 14'd0;     ref_value = 14'd3300; end
            6:     begin gain = 14'd6373;  ref_value = 14'd0;    end
            7:     begin gain = 14'h3FFF;  ref_value = 14'h3FFF; end
            default: begin
               gain      = CSR_DATA_W'($urandom_range(4096, 16383));
               ref_value = CSR_DATA_W'($urandom_range(1000, 5000));
            end
         endcase
         wait_drained();
         apply_setting(gain, ref_value);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         // Back the pipeline up into the request port
         if (phase == 1 || phase == 9) long_hold_asked++;
         count = (band_lo >= 0 && band_lo <= band_hi) ? 95 : 35;
         for (int n = 0; n < count; n++) send_sample(pick_code());
      end

      wait_drained();
      if (board.awaited.size() != 0) begin
         board.mismatches++;
         $display("%0t: %0d responses never arrived", $time, board.awaited.size());
      end

      $display("tb summary: %0d samples checked over %0d register settings,",
               board.checked, settings_used);
      $display("tb summary: four flow-control mixes and %0d long response holds",
               long_hold_given);
      if (board.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/bsoc_pkg.sv
hw/rtl/bsoc_front.sv
hw/rtl/bsoc_queue.sv
hw/rtl/bsoc_div.sv
hw/rtl/bsoc_back.sv
hw/rtl/battery_soc_interpolator_unit.sv
test/battery_soc_interpolator_unit_tb.sv
